@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the top-level unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(name, clock, rstn, pre, post, msg) \
	name: assert property (@(posedge clock) disable iff (!(rstn)) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clock, rstn, pre, post, msg) \
	name: assert property (@(posedge clock) disable iff (!(rstn)) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ hw/rtl/scts_pkg.sv @@
package scts_pkg;

	// Default number of series terms.
	localparam int unsigned N_TERMS_DEF = 24;

	// 2*pi in Q52, truncated.
	localparam logic [54:0] TWO_PI_Q52 = 55'h6487ED5110B461;

	// Multiples of 2*pi added to make the scaled angle nonnegative.
	localparam int unsigned RED_BIAS = 21;

	localparam logic signed [63:0] ONE_Q56 = 64'sh0100_0000_0000_0000;
	localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

	typedef enum logic {
		OP_SINE   = 1'b0,
		OP_COSINE = 1'b1
	} op_t;

	// Reduced angle with its function select.
	typedef struct packed {
		logic              op;
		logic signed [63:0] x;
	} head_t;

	// Everything one series step needs.
	typedef struct packed {
		logic              op;
		logic signed [63:0] term;
		logic [62:0]       x2;
		logic signed [63:0] sum;
	} lane_t;

	// Data that rides alongside a multiplier.
	typedef struct packed {
		logic              op;
		logic [62:0]       x2;
		logic signed [63:0] sum;
	} side_t;

endpackage

@@ hw/rtl/scts_mul.sv @@
// Signed by unsigned product, rounded and shifted right by SH, saturated.
module scts_mul #(
	parameter int unsigned SH   = 56,
	parameter bit          NEG  = 1'b0,
	parameter int unsigned SB_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld,
	input  logic signed [63:0] a,
	input  logic [62:0]        b,
	input  logic [SB_W-1:0]    sb,
	output logic               res_vld,
	output logic signed [63:0] res,
	output logic [SB_W-1:0]    res_sb
);
	localparam int unsigned PROD_W = 127;
	localparam int unsigned HI_W = PROD_W - SH - 63;
	localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (SH - 1);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic neg_s1, neg_s2, neg_s3, neg_s4;
	logic [SB_W-1:0] sb_s1, sb_s2, sb_s3, sb_s4, sb_s5;
	logic [63:0] mag_s1;
	logic [62:0] b_s1;
	logic [63:0] p00_s2, p10_s2;
	logic [62:0] p01_s2, p11_s2;
	logic [63:0] p00_s3;
	logic [62:0] p11_s3;
	logic [64:0] cross_s3;
	logic [PROD_W-1:0] prod_s4;
	logic signed [63:0] res_s5;

	logic sat;
	logic [62:0] mag_c;
	logic [63:0] mag64;

	assign sat = |prod_s4[PROD_W-1 -: HI_W];
	assign mag_c = sat ? {63{1'b1}} : prod_s4[SH +: 63];
	assign mag64 = {1'b0, mag_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// take magnitude, keep the sign apart
			neg_s1 <= a[63] ^ NEG;
			mag_s1 <= a[63] ? (~a + 64'd1) : a;
			b_s1   <= b;
			sb_s1  <= sb;

			// four 32-bit partial products
			p00_s2 <= mag_s1[31:0] * b_s1[31:0];
			p01_s2 <= mag_s1[31:0] * b_s1[62:32];
			p10_s2 <= mag_s1[63:32] * b_s1[31:0];
			p11_s2 <= mag_s1[63:32] * b_s1[62:32];
			neg_s2 <= neg_s1;
			sb_s2  <= sb_s1;

			p00_s3   <= p00_s2;
			p11_s3   <= p11_s2;
			cross_s3 <= {2'b00, p01_s2} + {1'b0, p10_s2};
			neg_s3   <= neg_s2;
			sb_s3    <= sb_s2;

			// full product plus half an output LSB
			prod_s4 <= {p11_s3, p00_s3} + {30'd0, cross_s3, 32'd0} + RND;
			neg_s4  <= neg_s3;
			sb_s4   <= sb_s3;

			res_s5 <= neg_s4 ? (~mag64 + 64'd1) : mag64;
			sb_s5  <= sb_s4;
		end
	end

	assign res_vld = vld_s5;
	assign res = res_s5;
	assign res_sb = sb_s5;

endmodule

@@ hw/rtl/scts_reduce.sv @@
// Floor modulo of the scaled angle by 2*pi, one quotient bit per stage.
module scts_reduce (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld,
	input  logic               op,
	input  logic signed [31:0] angle,
	output logic               nxt_vld,
	output scts_pkg::head_t    nxt
);
	import scts_pkg::*;

	localparam int unsigned RED_W = 61;
	localparam int unsigned BIG_W = RED_W + 1;
	localparam int unsigned STEPS = 6;
	localparam logic [BIG_W-1:0] OFS = BIG_W'(RED_BIAS) * BIG_W'(TWO_PI_Q52);

	logic [RED_W-1:0] rem_s [0:STEPS];
	logic vld_s [0:STEPS];
	logic op_s [0:STEPS];
	logic [BIG_W-1:0] big;
	logic [BIG_W-1:0] biased;

	// angle * 2^28 in Q52, lifted by a whole number of periods
	assign big = {{(BIG_W - 60){angle[31]}}, angle, 28'd0};
	assign biased = big + OFS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= biased[RED_W-1:0];
			op_s[0]  <= op;
		end
	end

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam logic [RED_W-1:0] DIV = RED_W'(TWO_PI_Q52) << (STEPS - 1 - j);
		logic [RED_W:0] diff;

		assign diff = {1'b0, rem_s[j]} - {1'b0, DIV};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		// subtract when it does not borrow
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= diff[RED_W] ? rem_s[j] : diff[RED_W-1:0];
				op_s[j+1]  <= op_s[j];
			end
		end
	end

	assign nxt_vld = vld_s[STEPS];
	assign nxt = '{op: op_s[STEPS], x: {5'd0, rem_s[STEPS][54:0], 4'd0}};

endmodule

@@ hw/rtl/scts_term.sv @@
// One series step: sum += term, term = -term * x^2 / (m(m+1)).
module scts_term #(
	parameter int unsigned IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld,
	input  scts_pkg::lane_t cur,
	output logic            nxt_vld,
	output scts_pkg::lane_t nxt
);
	import scts_pkg::*;

	localparam logic [63:0] DIV_SIN = 64'((2 * IDX + 2) * (2 * IDX + 3));
	localparam logic [63:0] DIV_COS = 64'((2 * IDX + 1) * (2 * IDX + 2));
	localparam logic [63:0] RCP_SIN = (ONE_Q62 + DIV_SIN / 64'd2) / DIV_SIN;
	localparam logic [63:0] RCP_COS = (ONE_Q62 + DIV_COS / 64'd2) / DIV_COS;

	side_t side_in, side_mid, side_out;
	logic [62:0] rcp;
	logic mid_vld;
	logic signed [63:0] mid_term;
	logic signed [63:0] nxt_term;

	assign side_in = '{op: cur.op, x2: cur.x2, sum: cur.sum + cur.term};
	assign rcp = (cur.op == OP_COSINE) ? RCP_COS[62:0] : RCP_SIN[62:0];

	scts_mul #(
		.SH  (62),
		.NEG (1'b0),
		.SB_W($bits(side_t))
	) u_mul_rcp (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (vld),
		.a      (cur.term),
		.b      (rcp),
		.sb     (side_in),
		.res_vld(mid_vld),
		.res    (mid_term),
		.res_sb (side_mid)
	);

	scts_mul #(
		.SH  (56),
		.NEG (1'b1),
		.SB_W($bits(side_t))
	) u_mul_sq (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (mid_vld),
		.a      (mid_term),
		.b      (side_mid.x2),
		.sb     (side_mid),
		.res_vld(nxt_vld),
		.res    (nxt_term),
		.res_sb (side_out)
	);

	assign nxt = '{op: side_out.op, term: nxt_term, x2: side_out.x2, sum: side_out.sum};

endmodule

@@ hw/rtl/sine_cosine_taylor_series_unit.sv @@
// Sine / cosine unit, fixed-length Maclaurin series.
//
// Input channel: in_valid / in_stall with fields op (0 sine, 1 cosine) and
// angle (signed Q8.24 radians). Output channel: out_valid / out_stall with
// value (signed Q2.30, rounded, saturated). A transaction moves at a rising
// edge where valid is high and stall is low.
//
// Fully pipelined: one transaction per cycle in and out while the receiver
// does not stall. The pipeline is 7 stages of range reduction (a load stage,
// then one quotient bit per stage), 5 for x^2, then 10 per series step (two
// 5-stage multipliers), 2 to finish and round, and the output register.
//
// Reset clears all valid bits; no item is in flight after reset.
// When the receiver stalls, the output register holds its result and the
// next result to arrive drops into a skid register; the whole pipeline then
// freezes and in_stall rises, so nothing is lost or repeated.
`include "assert_macros.svh"

module sine_cosine_taylor_series_unit #(
	parameter int unsigned N_TERMS = scts_pkg::N_TERMS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic signed [31:0] angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value
);
	import scts_pkg::*;

	localparam logic signed [63:0] HALF_LSB = 64'sh0000_0000_0200_0000;
	localparam logic [31:0] Q30_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q30_MIN = 32'h8000_0000;

	logic pipe_en;

	head_t red_out;
	logic red_vld;
	head_t sq_head;
	logic sq_vld;
	logic signed [63:0] sq;

	lane_t lane [0:N_TERMS-1];
	logic lane_vld [0:N_TERMS-1];

	logic fin_vld_s1, fin_vld_s2;
	logic signed [63:0] fin_sum_s1;
	logic [31:0] fin_value_s2;

	logic signed [63:0] rnd_sum;
	logic signed [63:0] shr;
	logic [31:0] sat_value;

	logic out_vld_q, skid_vld_q;
	logic [31:0] out_value_q, skid_value_q;

	// Freeze the whole pipeline once the skid register is occupied.
	assign pipe_en = !skid_vld_q;
	assign in_stall = skid_vld_q;

	// Range reduction into [0, 2pi), Q56.
	scts_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (pipe_en),
		.vld    (in_valid),
		.op     (op),
		.angle  (angle),
		.nxt_vld(red_vld),
		.nxt    (red_out)
	);

	// x^2 in Q56.
	scts_mul #(
		.SH  (56),
		.NEG (1'b0),
		.SB_W($bits(head_t))
	) u_mul_x2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (pipe_en),
		.vld    (red_vld),
		.a      (red_out.x),
		.b      (red_out.x[62:0]),
		.sb     (red_out),
		.res_vld(sq_vld),
		.res    (sq),
		.res_sb (sq_head)
	);

	// First term: x for sine, 1.0 for cosine; empty sum.
	assign lane_vld[0] = sq_vld;
	assign lane[0] = '{
		op:   sq_head.op,
		term: (sq_head.op == OP_COSINE) ? ONE_Q56 : sq_head.x,
		x2:   sq[62:0],
		sum:  64'sd0
	};

	// One step unit per term update.
	for (genvar i = 0; i < N_TERMS - 1; i++) begin : g_term
		scts_term #(
			.IDX(i)
		) u_term (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (pipe_en),
			.vld    (lane_vld[i]),
			.cur    (lane[i]),
			.nxt_vld(lane_vld[i+1]),
			.nxt    (lane[i+1])
		);
	end

	// Round to Q2.30 (ties toward +inf) and clamp.
	assign rnd_sum = fin_sum_s1 + HALF_LSB;
	assign shr = rnd_sum >>> 26;
	always_comb begin
		if ((&shr[63:31]) || !(|shr[63:31])) begin
			sat_value = shr[31:0];
		end else begin
			sat_value = shr[63] ? Q30_MIN : Q30_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_s1 <= 1'b0;
			fin_vld_s2 <= 1'b0;
		end else if (pipe_en) begin
			fin_vld_s1 <= lane_vld[N_TERMS-1];
			fin_vld_s2 <= fin_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			// add the last term
			fin_sum_s1   <= lane[N_TERMS-1].sum + lane[N_TERMS-1].term;
			fin_value_s2 <= sat_value;
		end
	end

	// Output register with a one-entry skid behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !out_stall) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= fin_vld_s2;
			end
		end else if (fin_vld_s2 && !skid_vld_q) begin
			// output is held: park the arriving result
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !out_stall) begin
			out_value_q <= skid_vld_q ? skid_value_q : fin_value_s2;
		end else if (!skid_vld_q) begin
			skid_value_q <= fin_value_s2;
		end
	end

	assign out_valid = out_vld_q;
	assign value = out_value_q;

	`ASSERT_IMPLIES(a_skid_behind_out, clk, arst_n, skid_vld_q, out_vld_q, "skid full with empty output register")
	`ASSERT_NEXT(a_skid_catch, clk, arst_n, out_vld_q && out_stall && fin_vld_s2 && !skid_vld_q, skid_vld_q, "result dropped while output stalled")
	`ASSERT_IMPLIES(a_skid_cause, clk, arst_n, $rose(skid_vld_q), $past(out_vld_q && out_stall), "skid filled without an output stall")

endmodule
